>>> rtl/core/rvex_pkg.sv
// shared types, opcodes and helpers of the rv64im execute unit
// no dependencies; every other file in rtl/core uses it by scoped names
package rvex_pkg;

	localparam int DIV_STEPS = 64;
	localparam int DIV_LAT   = DIV_STEPS + 1;
	localparam int MUL_LAT   = 4;

	localparam logic [6:0] OPC_OP      = 7'h33;
	localparam logic [6:0] OPC_OP32    = 7'h3b;
	localparam logic [6:0] OPC_LOAD    = 7'h03;
	localparam logic [6:0] OPC_OPIMM   = 7'h13;
	localparam logic [6:0] OPC_OPIMM32 = 7'h1b;
	localparam logic [6:0] OPC_JALR    = 7'h67;
	localparam logic [6:0] OPC_SYSTEM  = 7'h73;
	localparam logic [6:0] OPC_STORE   = 7'h23;
	localparam logic [6:0] OPC_BRANCH  = 7'h63;
	localparam logic [6:0] OPC_AUIPC   = 7'h17;
	localparam logic [6:0] OPC_LUI     = 7'h37;
	localparam logic [6:0] OPC_JAL     = 7'h6f;

	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT    = 7'h20;

	localparam logic [5:0] SHIFT_LOGIC = 6'h00;
	localparam logic [5:0] SHIFT_ARITH = 6'h10;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_MUL  = 3'd0;
	localparam logic [2:0] F3_MULH = 3'd1;
	localparam logic [2:0] F3_DIV  = 3'd4;
	localparam logic [2:0] F3_DIVU = 3'd5;
	localparam logic [2:0] F3_REM  = 3'd6;
	localparam logic [2:0] F3_REMU = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_PLAIN       = 3'd0;
	localparam logic [2:0] LOAD_RESERVED  = 3'd7;

	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_LOAD  = 2'd1,
		MEM_STORE = 2'd2
	} mem_kind_t;

	typedef enum logic [1:0] {
		FAULT_NONE     = 2'd0,
		FAULT_ILLEGAL  = 2'd1,
		FAULT_ECALL    = 2'd2,
		FAULT_MISALIGN = 2'd3
	} fault_t;

	typedef enum logic [1:0] {
		UNIT_ALU = 2'd0,
		UNIT_MUL = 2'd1,
		UNIT_DIV = 2'd2
	} unit_t;

	typedef enum logic [1:0] {
		MUL_LO   = 2'd0,
		MUL_HI   = 2'd1,
		MUL_WORD = 2'd2
	} mul_op_t;

	typedef struct packed {
		logic [31:0] instruction;
		logic [63:0] source_a;
		logic [63:0] source_b;
		logic [63:0] pc_value;
	} issue_t;

	typedef struct packed {
		logic [4:0]  dest_index;
		logic        dest_write;
		logic [63:0] dest_value;
		logic        jump_taken;
		logic [63:0] jump_target;
		mem_kind_t   mem_kind;
		logic [1:0]  mem_size_log;
		logic        mem_signed;
		logic [63:0] mem_address;
		logic [63:0] store_value;
		fault_t      fault;
	} result_t;

	typedef struct packed {
		logic rem;
		logic neg;
		logic word;
	} div_ctl_t;

	typedef struct packed {
		result_t     res;
		unit_t       unit;
		mul_op_t     mul_op;
		div_ctl_t    div_ctl;
		logic [63:0] opa;
		logic [63:0] opb;
	} work_t;

	function automatic logic [63:0] sext32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

endpackage

>>> rtl/core/rvex_front.sv
// instruction classifier: decodes one word combinationally, does all work
// outside the multiply and divide pipes and prepares their operands; uses rvex_pkg
module rvex_front (
	input  rvex_pkg::issue_t issue,
	output rvex_pkg::work_t  work
);

	logic [31:0] ins;
	logic [63:0] a, b, pc;
	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [63:0] iimm, simm, bimm, uimm, jimm;
	logic [63:0] opnd, mimm, pimm;
	logic [5:0]  shamt;
	logic [4:0]  shamt_w;
	logic [63:0] alu_add, alu_sub, shl, shr, sar;
	logic [63:0] addw, subw, sllw, srlw, sraw;
	logic [31:0] sraw32;
	logic        lt_s, lt_u, eq;
	logic [63:0] maddr, ptgt, link;
	logic        mis;
	logic [63:0] dva, dvb, ua, ub, dzval;
	logic        na, nb, dzero;
	rvex_pkg::div_ctl_t dctl;

	logic               ok, wr, tk, ld, st;
	rvex_pkg::fault_t   flt, flt_fin;
	rvex_pkg::unit_t    unit;
	rvex_pkg::mul_op_t  mop;
	logic [63:0]        val, tgt;

	assign ins = issue.instruction;
	assign a   = issue.source_a;
	assign b   = issue.source_b;
	assign pc  = issue.pc_value;

	assign opc = ins[6:0];
	assign rd  = ins[11:7];
	assign f3  = ins[14:12];
	assign f7  = ins[31:25];

	assign iimm = {{52{ins[31]}}, ins[31:20]};
	assign simm = {{52{ins[31]}}, ins[31:25], ins[11:7]};
	assign bimm = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
	assign uimm = {{32{ins[31]}}, ins[31:12], 12'b0};
	assign jimm = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

	// register forms and branches compare against rs2, the rest against the immediate
	assign opnd = (opc == rvex_pkg::OPC_OP || opc == rvex_pkg::OPC_OP32 ||
		opc == rvex_pkg::OPC_BRANCH) ? b : iimm;
	assign shamt   = opnd[5:0];
	assign shamt_w = opnd[4:0];

	assign alu_add = a + opnd;
	assign alu_sub = a - b;
	assign shl     = a << shamt;
	assign shr     = a >> shamt;
	assign sar     = $signed(a) >>> shamt;
	assign lt_s    = $signed(a) < $signed(opnd);
	assign lt_u    = a < opnd;
	assign eq      = a == opnd;

	assign addw   = rvex_pkg::sext32(alu_add);
	assign subw   = rvex_pkg::sext32(alu_sub);
	assign sllw   = rvex_pkg::sext32(a << shamt_w);
	assign srlw   = rvex_pkg::sext32({32'b0, a[31:0]} >> shamt_w);
	assign sraw32 = $signed(a[31:0]) >>> shamt_w;
	assign sraw   = rvex_pkg::sext32({32'b0, sraw32});

	assign mimm  = (opc == rvex_pkg::OPC_STORE) ? simm : iimm;
	assign maddr = a + mimm;
	assign link  = pc + 64'd4;
	assign ptgt  = pc + pimm;

	always_comb begin
		case (opc)
			rvex_pkg::OPC_AUIPC: pimm = uimm;
			rvex_pkg::OPC_JAL:   pimm = jimm;
			default:             pimm = bimm;
		endcase
	end

	always_comb begin
		case (f3[1:0])
			2'd0:    mis = 1'b0;
			2'd1:    mis = maddr[0];
			2'd2:    mis = |maddr[1:0];
			default: mis = |maddr[2:0];
		endcase
	end

	// divide operands as magnitudes; sign fix-up happens after the last step
	assign dva   = (opc == rvex_pkg::OPC_OP32) ? rvex_pkg::sext32(a) : a;
	assign dvb   = (opc == rvex_pkg::OPC_OP32) ? rvex_pkg::sext32(b) : b;
	assign na    = !f3[0] && dva[63];
	assign nb    = !f3[0] && dvb[63];
	assign ua    = na ? (64'd0 - dva) : dva;
	assign ub    = nb ? (64'd0 - dvb) : dvb;
	assign dzero = dvb == 64'd0;
	assign dzval = f3[1] ? dva : '1;
	assign dctl.rem  = f3[1];
	assign dctl.neg  = f3[1] ? na : (na ^ nb);
	assign dctl.word = opc == rvex_pkg::OPC_OP32;

	always_comb begin
		ok   = 1'b1;
		wr   = 1'b0;
		tk   = 1'b0;
		ld   = 1'b0;
		st   = 1'b0;
		flt  = rvex_pkg::FAULT_NONE;
		unit = rvex_pkg::UNIT_ALU;
		mop  = rvex_pkg::MUL_LO;
		val  = '0;
		tgt  = '0;
		case (opc)
			rvex_pkg::OPC_OP: begin
				wr = 1'b1;
				case (f7)
					rvex_pkg::F7_BASE: begin
						case (f3)
							rvex_pkg::F3_ADD:  val = alu_add;
							rvex_pkg::F3_SLL:  val = shl;
							rvex_pkg::F3_SLT:  val = {63'b0, lt_s};
							rvex_pkg::F3_SLTU: val = {63'b0, lt_u};
							rvex_pkg::F3_XOR:  val = a ^ opnd;
							rvex_pkg::F3_SR:   val = shr;
							rvex_pkg::F3_OR:   val = a | opnd;
							default:           val = a & opnd;
						endcase
					end
					rvex_pkg::F7_MULDIV: begin
						case (f3)
							rvex_pkg::F3_MUL: unit = rvex_pkg::UNIT_MUL;
							rvex_pkg::F3_MULH: begin
								unit = rvex_pkg::UNIT_MUL;
								mop  = rvex_pkg::MUL_HI;
							end
							rvex_pkg::F3_DIV, rvex_pkg::F3_DIVU,
							rvex_pkg::F3_REM, rvex_pkg::F3_REMU: begin
								if (dzero) begin
									val = dzval;
								end else begin
									unit = rvex_pkg::UNIT_DIV;
								end
							end
							default: ok = 1'b0;
						endcase
					end
					rvex_pkg::F7_ALT: begin
						case (f3)
							rvex_pkg::F3_ADD: val = alu_sub;
							rvex_pkg::F3_SR:  val = sar;
							default:          ok = 1'b0;
						endcase
					end
					default: ok = 1'b0;
				endcase
			end
			rvex_pkg::OPC_OP32: begin
				wr = 1'b1;
				case (f7)
					rvex_pkg::F7_BASE: begin
						if (f3 == rvex_pkg::F3_ADD) val = addw;
						else ok = 1'b0;
					end
					rvex_pkg::F7_MULDIV: begin
						case (f3)
							rvex_pkg::F3_MUL: begin
								unit = rvex_pkg::UNIT_MUL;
								mop  = rvex_pkg::MUL_WORD;
							end
							rvex_pkg::F3_DIV, rvex_pkg::F3_REM: begin
								if (dzero) begin
									val = dzval;
								end else begin
									unit = rvex_pkg::UNIT_DIV;
								end
							end
							default: ok = 1'b0;
						endcase
					end
					rvex_pkg::F7_ALT: begin
						if (f3 == rvex_pkg::F3_ADD) val = subw;
						else ok = 1'b0;
					end
					default: ok = 1'b0;
				endcase
			end
			rvex_pkg::OPC_OPIMM: begin
				wr = 1'b1;
				case (f3)
					rvex_pkg::F3_ADD: val = alu_add;
					rvex_pkg::F3_SLL: begin
						if (f7[6:1] == rvex_pkg::SHIFT_LOGIC) val = shl;
						else ok = 1'b0;
					end
					rvex_pkg::F3_SLT: val = {63'b0, lt_s};
					rvex_pkg::F3_XOR: val = a ^ opnd;
					rvex_pkg::F3_SR: begin
						if (f7[6:1] == rvex_pkg::SHIFT_LOGIC) val = shr;
						else if (f7[6:1] == rvex_pkg::SHIFT_ARITH) val = sar;
						else ok = 1'b0;
					end
					rvex_pkg::F3_OR:  val = a | opnd;
					rvex_pkg::F3_AND: val = a & opnd;
					default:          ok = 1'b0;
				endcase
			end
			rvex_pkg::OPC_OPIMM32: begin
				wr = 1'b1;
				case (f3)
					rvex_pkg::F3_ADD: val = addw;
					rvex_pkg::F3_SLL: begin
						if (f7[6:1] == rvex_pkg::SHIFT_LOGIC) val = sllw;
						else ok = 1'b0;
					end
					rvex_pkg::F3_SR: begin
						if (f7[6:1] == rvex_pkg::SHIFT_LOGIC) val = srlw;
						else if (f7[6:1] == rvex_pkg::SHIFT_ARITH) val = sraw;
						else ok = 1'b0;
					end
					default: ok = 1'b0;
				endcase
			end
			rvex_pkg::OPC_LUI: begin
				wr  = 1'b1;
				val = uimm;
			end
			rvex_pkg::OPC_AUIPC: begin
				wr  = 1'b1;
				val = ptgt;
			end
			rvex_pkg::OPC_JAL: begin
				wr  = 1'b1;
				tk  = 1'b1;
				val = link;
				tgt = ptgt;
			end
			rvex_pkg::OPC_JALR: begin
				if (f3 != rvex_pkg::F3_PLAIN) begin
					ok = 1'b0;
				end else begin
					wr  = 1'b1;
					tk  = 1'b1;
					val = link;
					tgt = {maddr[63:1], 1'b0};
				end
			end
			rvex_pkg::OPC_SYSTEM: begin
				if (f3 != rvex_pkg::F3_PLAIN) ok = 1'b0;
				else flt = rvex_pkg::FAULT_ECALL;
			end
			rvex_pkg::OPC_LOAD: begin
				if (f3 == rvex_pkg::LOAD_RESERVED) ok = 1'b0;
				else if (mis) flt = rvex_pkg::FAULT_MISALIGN;
				else ld = 1'b1;
			end
			rvex_pkg::OPC_STORE: begin
				if (f3[2]) ok = 1'b0;
				else if (mis) flt = rvex_pkg::FAULT_MISALIGN;
				else st = 1'b1;
			end
			rvex_pkg::OPC_BRANCH: begin
				tgt = ptgt;
				case (f3)
					rvex_pkg::F3_BEQ:  tk = eq;
					rvex_pkg::F3_BNE:  tk = !eq;
					rvex_pkg::F3_BLT:  tk = lt_s;
					rvex_pkg::F3_BGE:  tk = !lt_s;
					rvex_pkg::F3_BLTU: tk = lt_u;
					rvex_pkg::F3_BGEU: tk = !lt_u;
					default:           ok = 1'b0;
				endcase
			end
			default: ok = 1'b0;
		endcase
	end

	assign flt_fin = ok ? flt : rvex_pkg::FAULT_ILLEGAL;

	always_comb begin
		work = '0;
		if (flt_fin != rvex_pkg::FAULT_NONE) begin
			work.res.fault = flt_fin;
		end else begin
			if (wr) begin
				work.res.dest_index = rd;
				// x0 drops the write, and with it any mul/div work
				if (rd != 5'd0) begin
					work.res.dest_write = 1'b1;
					work.res.dest_value = val;
					work.unit           = unit;
					work.mul_op         = mop;
					work.div_ctl        = dctl;
					if (unit == rvex_pkg::UNIT_DIV) begin
						work.opa = ua;
						work.opb = ub;
					end else if (unit == rvex_pkg::UNIT_MUL) begin
						work.opa = a;
						work.opb = b;
					end
				end
			end
			if (ld) begin
				work.res.dest_index   = rd;
				work.res.mem_kind     = rvex_pkg::MEM_LOAD;
				work.res.mem_size_log = f3[1:0];
				work.res.mem_signed   = !f3[2];
				work.res.mem_address  = maddr;
			end
			if (st) begin
				work.res.mem_kind     = rvex_pkg::MEM_STORE;
				work.res.mem_size_log = f3[1:0];
				work.res.mem_address  = maddr;
				work.res.store_value  = b;
			end
			work.res.jump_taken  = tk;
			work.res.jump_target = tk ? tgt : '0;
		end
	end

endmodule

>>> rtl/core/rvex_fifo.sv
// short queue of classified instructions between front and back
// holds rvex_pkg::work_t entries
module rvex_fifo #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_stall,
	input  rvex_pkg::work_t   push_data,
	input  logic              pop,
	output logic              pop_valid,
	output rvex_pkg::work_t   pop_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rvex_pkg::work_t entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            push;

	assign push_stall = cnt_q == CW'(DEPTH);
	assign push       = push_valid && !push_stall;
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> rtl/core/rvex_mul.sv
// four-stage 64x64 multiplier from 32x32 partial products
// low half, signed high half, or word result; uses rvex_pkg
module rvex_mul (
	input  logic              clk,
	input  logic              en,
	input  logic [63:0]       a,
	input  logic [63:0]       b,
	input  rvex_pkg::mul_op_t op,
	output logic [63:0]       res
);

	logic [63:0]       p00_s1, p01_s1, p10_s1, p11_s1, corr_s1;
	rvex_pkg::mul_op_t op_s1, op_s2, op_s3;
	logic [64:0]       mid_s2;
	logic [63:0]       p00_s2, p11_s2, corr_s2, corr_s3;
	logic [127:0]      full_s3;
	logic [63:0]       res_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= a[31:0] * b[31:0];
			p01_s1  <= a[31:0] * b[63:32];
			p10_s1  <= a[63:32] * b[31:0];
			p11_s1  <= a[63:32] * b[63:32];
			// unsigned-to-signed high half correction
			corr_s1 <= (a[63] ? b : 64'd0) + (b[63] ? a : 64'd0);
			op_s1   <= op;

			mid_s2  <= {1'b0, p01_s1} + {1'b0, p10_s1};
			p00_s2  <= p00_s1;
			p11_s2  <= p11_s1;
			corr_s2 <= corr_s1;
			op_s2   <= op_s1;

			full_s3 <= {p11_s2, p00_s2} + {31'b0, mid_s2, 32'b0};
			corr_s3 <= corr_s2;
			op_s3   <= op_s2;

			case (op_s3)
				rvex_pkg::MUL_HI:   res_s4 <= full_s3[127:64] - corr_s3;
				rvex_pkg::MUL_WORD: res_s4 <= rvex_pkg::sext32(full_s3[63:0]);
				default:            res_s4 <= full_s3[63:0];
			endcase
		end
	end

	assign res = res_s4;

endmodule

>>> rtl/core/rvex_div.sv
// pipelined restoring divider, one quotient bit per stage, then sign fix-up
// operands arrive as magnitudes; uses rvex_pkg
module rvex_div (
	input  logic               clk,
	input  logic               en,
	input  logic [63:0]        dividend,
	input  logic [63:0]        divisor,
	input  rvex_pkg::div_ctl_t ctl,
	output logic [63:0]        res
);

	logic [63:0]        rem_s [rvex_pkg::DIV_STEPS];
	logic [63:0]        quo_s [rvex_pkg::DIV_STEPS];
	logic [63:0]        dvs_s [rvex_pkg::DIV_STEPS];
	rvex_pkg::div_ctl_t ctl_s [rvex_pkg::DIV_STEPS];
	logic [63:0]        pick, signed_val;
	logic [63:0]        res_s65;

	for (genvar k = 0; k < rvex_pkg::DIV_STEPS; k++) begin : g_step
		logic [63:0]        rem_in, quo_in, dvs_in;
		rvex_pkg::div_ctl_t ctl_in;
		logic [64:0]        part, diff;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = dividend;
			assign dvs_in = divisor;
			assign ctl_in = ctl;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign ctl_in = ctl_s[k-1];
		end

		// shift next dividend bit in, subtract if it fits
		assign part = {rem_in, quo_in[63]};
		assign diff = part - {1'b0, dvs_in};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[64]) begin
					rem_s[k] <= diff[63:0];
					quo_s[k] <= {quo_in[62:0], 1'b1};
				end else begin
					rem_s[k] <= part[63:0];
					quo_s[k] <= {quo_in[62:0], 1'b0};
				end
				dvs_s[k] <= dvs_in;
				ctl_s[k] <= ctl_in;
			end
		end
	end

	assign pick = ctl_s[rvex_pkg::DIV_STEPS-1].rem ? rem_s[rvex_pkg::DIV_STEPS-1]
		: quo_s[rvex_pkg::DIV_STEPS-1];
	assign signed_val = ctl_s[rvex_pkg::DIV_STEPS-1].neg ? (64'd0 - pick) : pick;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s65 <= ctl_s[rvex_pkg::DIV_STEPS-1].word ? rvex_pkg::sext32(signed_val)
				: signed_val;
		end
	end

	assign res = res_s65;

endmodule

>>> rtl/core/rvex_back.sv
// execution back end: fixed-length lockstep line with mul and div pipes
// merged into it, output register at the end; uses rvex_pkg, rvex_mul, rvex_div
module rvex_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take_valid,
	input  rvex_pkg::work_t   work,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output rvex_pkg::result_t result
);

	localparam int LAT = rvex_pkg::DIV_LAT;

	logic              adv;
	logic              vld_s [LAT];
	rvex_pkg::result_t res_s [LAT];
	rvex_pkg::unit_t   unit_s [LAT];
	logic              out_valid_q;
	rvex_pkg::result_t out_q;
	logic [63:0]       mul_res, div_res;
	rvex_pkg::result_t mul_merged, div_merged;

	// whole line moves as one unless a finished beat is held at the output
	assign adv = !out_valid_q || !result_stall;
	assign pop = adv && take_valid;

	rvex_mul u_mul (
		.clk (clk),
		.en  (adv),
		.a   (work.opa),
		.b   (work.opb),
		.op  (work.mul_op),
		.res (mul_res)
	);

	rvex_div u_div (
		.clk      (clk),
		.en       (adv),
		.dividend (work.opa),
		.divisor  (work.opb),
		.ctl      (work.div_ctl),
		.res      (div_res)
	);

	always_comb begin
		mul_merged = res_s[rvex_pkg::MUL_LAT-1];
		if (unit_s[rvex_pkg::MUL_LAT-1] == rvex_pkg::UNIT_MUL) begin
			mul_merged.dest_value = mul_res;
		end
		div_merged = res_s[LAT-1];
		if (unit_s[LAT-1] == rvex_pkg::UNIT_DIV) begin
			div_merged.dest_value = div_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= take_valid;
			for (int k = 1; k < LAT; k++) vld_s[k] <= vld_s[k-1];
			out_valid_q <= vld_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s[0]  <= work.res;
			unit_s[0] <= work.unit;
			for (int k = 1; k < LAT; k++) begin
				res_s[k]  <= (k == rvex_pkg::MUL_LAT) ? mul_merged : res_s[k-1];
				unit_s[k] <= unit_s[k-1];
			end
			out_q <= div_merged;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> rtl/core/rv64im_execute_unit.sv
// Execute stage for the RV64IM subset: one instruction in, one result beat out.
// Every instruction travels in lockstep with the 64-step divide pipeline from
// leaving the queue to its result beat; one instruction is taken per cycle
// while the result side keeps up. A QUEUE_DEPTH-entry queue (two by default)
// sits behind the classifier, so the input is held off only once the queue
// fills during a result stall. Results leave in issue order.
// Depends on rvex_pkg, rvex_front, rvex_fifo, rvex_back.
module rv64im_execute_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              issue_valid,
	output logic              issue_stall,
	input  rvex_pkg::issue_t  issue,
	output logic              result_valid,
	input  logic              result_stall,
	output rvex_pkg::result_t result
);

	rvex_pkg::work_t front_work, queue_work;
	logic            queue_valid, queue_pop;

	rvex_front u_front (
		.issue (issue),
		.work  (front_work)
	);

	rvex_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (issue_valid),
		.push_stall (issue_stall),
		.push_data  (front_work),
		.pop        (queue_pop),
		.pop_valid  (queue_valid),
		.pop_data   (queue_work)
	);

	rvex_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.take_valid   (queue_valid),
		.work         (queue_work),
		.pop          (queue_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTH
	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.fault != rvex_pkg::FAULT_NONE |->
		!result.dest_write && !result.jump_taken && result.mem_kind == rvex_pkg::MEM_NONE)
		else $error("faulting result carries side effects");

	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dest_write |-> result.dest_index != 5'd0)
		else $error("register write to x0");

	a_mem_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.mem_kind != rvex_pkg::MEM_NONE |->
		!result.dest_write && !result.jump_taken)
		else $error("memory request mixed with write or jump");
`endif

endmodule

>>> verif/rv64im_execute_unit_tb.sv
// testbench for rv64im_execute_unit: random and directed instruction beats,
// each result checked field by field against an in-bench RV64IM predictor
// depends on rvex_pkg and the execute unit rtl
module rv64im_execute_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 70;
	localparam int CYCLE_LIMIT = 400000;

	logic              clk;
	logic              arst_n;
	logic              issue_valid;
	logic              issue_stall;
	rvex_pkg::issue_t  issue;
	logic              result_valid;
	logic              result_stall;
	rvex_pkg::result_t result;

	rvex_pkg::issue_t  pending_beats[$];
	rvex_pkg::result_t expected_results[$];
	int      error_count;
	int      cycle_count;
	int      hold_count;
	int      hold_off_start;
	int      issue_gap;
	int      result_gap;
	bit      issue_taken;
	bit      result_taken;

	rv64im_execute_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.issue_valid(issue_valid),
		.issue_stall(issue_stall),
		.issue(issue),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] sx_bits(input logic [63:0] v, input int bits);
		logic [63:0] m;
		m = 64'd1 << (bits - 1);
		v = v & ((m << 1) - 64'd1);
		return (v ^ m) - m;
	endfunction

	function automatic logic [63:0] divide_signed(input logic [63:0] a, input logic [63:0] b,
			input bit want_rem);
		logic [63:0] ua, ub, q, r;
		if (b == 64'd0)
			return want_rem ? a : '1;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		q = ua / ub;
		r = ua % ub;
		if (a[63] != b[63])
			q = -q;
		if (a[63])
			r = -r;
		return want_rem ? r : q;
	endfunction

	function automatic logic [63:0] mul_high_signed(input logic [63:0] a, input logic [63:0] b);
		logic signed [127:0] p;
		p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
		return p[127:64];
	endfunction

	function automatic rvex_pkg::result_t execute_instruction(input rvex_pkg::issue_t it);
		rvex_pkg::result_t r;
		logic [31:0] ins;
		logic [63:0] a, b, pc, iimm, simm, bimm, uimm, jimm, val, addr;
		logic [6:0] opc, f7;
		logic [4:0] rd;
		logic [2:0] f3;
		logic [5:0] sh;
		bit ok, writes, taken;
		rvex_pkg::fault_t flt;
		ins = it.instruction;
		a = it.source_a;
		b = it.source_b;
		pc = it.pc_value;
		opc = ins[6:0];
		rd = ins[11:7];
		f3 = ins[14:12];
		f7 = ins[31:25];
		iimm = sx_bits(ins[31:20], 12);
		simm = sx_bits({ins[31:25], ins[11:7]}, 12);
		bimm = sx_bits({ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
		uimm = sx_bits({ins[31:12], 12'd0}, 32);
		jimm = sx_bits({ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
		r = '0;
		val = '0;
		ok = 1;
		writes = 0;
		taken = 0;
		flt = rvex_pkg::FAULT_NONE;
		case (opc)
			rvex_pkg::OPC_OP: begin
				writes = 1;
				if (f7 == rvex_pkg::F7_BASE) begin
					case (f3)
						rvex_pkg::F3_ADD: val = a + b;
						rvex_pkg::F3_SLL: val = a << b[5:0];
						rvex_pkg::F3_SLT: val = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
						rvex_pkg::F3_SLTU: val = (a < b) ? 64'd1 : 64'd0;
						rvex_pkg::F3_XOR: val = a ^ b;
						rvex_pkg::F3_SR: val = a >> b[5:0];
						rvex_pkg::F3_OR: val = a | b;
						default: val = a & b;
					endcase
				end else if (f7 == rvex_pkg::F7_MULDIV) begin
					case (f3)
						rvex_pkg::F3_MUL: val = a * b;
						rvex_pkg::F3_MULH: val = mul_high_signed(a, b);
						rvex_pkg::F3_DIV: val = divide_signed(a, b, 0);
						rvex_pkg::F3_DIVU: val = (b == 0) ? '1 : a / b;
						rvex_pkg::F3_REM: val = divide_signed(a, b, 1);
						rvex_pkg::F3_REMU: val = (b == 0) ? a : a % b;
						default: ok = 0;
					endcase
				end else if (f7 == rvex_pkg::F7_ALT && f3 == rvex_pkg::F3_ADD) begin
					val = a - b;
				end else if (f7 == rvex_pkg::F7_ALT && f3 == rvex_pkg::F3_SR) begin
					val = $signed(a) >>> b[5:0];
				end else begin
					ok = 0;
				end
			end
			rvex_pkg::OPC_OP32: begin
				writes = 1;
				if (f3 == rvex_pkg::F3_ADD && f7 == rvex_pkg::F7_BASE)
					val = sx_bits(a + b, 32);
				else if (f3 == rvex_pkg::F3_MUL && f7 == rvex_pkg::F7_MULDIV)
					val = sx_bits(a * b, 32);
				else if (f3 == rvex_pkg::F3_ADD && f7 == rvex_pkg::F7_ALT)
					val = sx_bits(a - b, 32);
				else if (f3 == rvex_pkg::F3_DIV && f7 == rvex_pkg::F7_MULDIV)
					val = sx_bits(divide_signed(sx_bits(a, 32), sx_bits(b, 32), 0), 32);
				else if (f3 == rvex_pkg::F3_REM && f7 == rvex_pkg::F7_MULDIV)
					val = sx_bits(divide_signed(sx_bits(a, 32), sx_bits(b, 32), 1), 32);
				else
					ok = 0;
			end
			rvex_pkg::OPC_OPIMM: begin
				writes = 1;
				sh = iimm[5:0];
				case (f3)
					rvex_pkg::F3_ADD: val = a + iimm;
					rvex_pkg::F3_SLL: begin
						if (f7[6:1] != rvex_pkg::SHIFT_LOGIC) ok = 0;
						else val = a << sh;
					end
					rvex_pkg::F3_SLT: val = ($signed(a) < $signed(iimm)) ? 64'd1 : 64'd0;
					rvex_pkg::F3_XOR: val = a ^ iimm;
					rvex_pkg::F3_SR: begin
						if (f7[6:1] == rvex_pkg::SHIFT_LOGIC)
							val = a >> sh;
						else if (f7[6:1] == rvex_pkg::SHIFT_ARITH)
							val = $signed(a) >>> sh;
						else
							ok = 0;
					end
					rvex_pkg::F3_OR: val = a | iimm;
					rvex_pkg::F3_AND: val = a & iimm;
					default: ok = 0;
				endcase
			end
			rvex_pkg::OPC_OPIMM32: begin
				writes = 1;
				sh = {1'b0, iimm[4:0]};
				case (f3)
					rvex_pkg::F3_ADD: val = sx_bits(a + iimm, 32);
					rvex_pkg::F3_SLL: begin
						if (f7[6:1] != rvex_pkg::SHIFT_LOGIC) ok = 0;
						else val = sx_bits(a << sh, 32);
					end
					rvex_pkg::F3_SR: begin
						if (f7[6:1] == rvex_pkg::SHIFT_LOGIC)
							val = sx_bits({32'd0, a[31:0]} >> sh, 32);
						else if (f7[6:1] == rvex_pkg::SHIFT_ARITH)
							val = sx_bits($signed(sx_bits(a, 32)) >>> sh, 32);
						else
							ok = 0;
					end
					default: ok = 0;
				endcase
			end
			rvex_pkg::OPC_LUI: begin
				writes = 1;
				val = uimm;
			end
			rvex_pkg::OPC_AUIPC: begin
				writes = 1;
				val = pc + uimm;
			end
			rvex_pkg::OPC_JAL: begin
				writes = 1;
				taken = 1;
				val = pc + 4;
				r.jump_target = pc + jimm;
			end
			rvex_pkg::OPC_JALR: begin
				if (f3 != rvex_pkg::F3_PLAIN) begin
					ok = 0;
				end else begin
					writes = 1;
					taken = 1;
					val = pc + 4;
					r.jump_target = (a + iimm) & ~64'd1;
				end
			end
			rvex_pkg::OPC_SYSTEM: begin
				if (f3 != rvex_pkg::F3_PLAIN) ok = 0; else flt = rvex_pkg::FAULT_ECALL;
			end
			rvex_pkg::OPC_LOAD: begin
				addr = a + iimm;
				if (f3 == rvex_pkg::LOAD_RESERVED) begin
					ok = 0;
				end else if ((addr & ((64'd1 << f3[1:0]) - 1)) != 0) begin
					flt = rvex_pkg::FAULT_MISALIGN;
				end else begin
					r.dest_index = rd;
					r.mem_kind = rvex_pkg::MEM_LOAD;
					r.mem_size_log = f3[1:0];
					r.mem_signed = !f3[2];
					r.mem_address = addr;
				end
			end
			rvex_pkg::OPC_STORE: begin
				addr = a + simm;
				if (f3 > 3) begin
					ok = 0;
				end else if ((addr & ((64'd1 << f3[1:0]) - 1)) != 0) begin
					flt = rvex_pkg::FAULT_MISALIGN;
				end else begin
					r.mem_kind = rvex_pkg::MEM_STORE;
					r.mem_size_log = f3[1:0];
					r.mem_address = addr;
					r.store_value = b;
				end
			end
			rvex_pkg::OPC_BRANCH: begin
				case (f3)
					rvex_pkg::F3_BEQ: taken = (a == b);
					rvex_pkg::F3_BNE: taken = (a != b);
					rvex_pkg::F3_BLT: taken = $signed(a) < $signed(b);
					rvex_pkg::F3_BGE: taken = !($signed(a) < $signed(b));
					rvex_pkg::F3_BLTU: taken = a < b;
					rvex_pkg::F3_BGEU: taken = a >= b;
					default: ok = 0;
				endcase
				if (ok && taken)
					r.jump_target = pc + bimm;
			end
			default: ok = 0;
		endcase
		if (!ok)
			flt = rvex_pkg::FAULT_ILLEGAL;
		if (flt != rvex_pkg::FAULT_NONE) begin
			r = '0;
			r.fault = flt;
		end else begin
			if (writes) begin
				r.dest_index = rd;
				if (rd != 0) begin
					r.dest_write = 1'b1;
					r.dest_value = val;
				end
			end
			r.jump_taken = taken;
			if (!taken)
				r.jump_target = '0;
		end
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = 64'h8000_0000_0000_0000;
			3: v = 64'h7fff_ffff_ffff_ffff;
			4: v = sx_bits(v, 32);
			5: v = v & 64'hff;
			default: ;
		endcase
		return v;
	endfunction

	// mostly decodable words with random fields, some pure noise
	function automatic logic [31:0] random_instruction();
		logic [31:0] w;
		logic [6:0] opcodes[12];
		logic [6:0] f7s[3];
		opcodes = '{rvex_pkg::OPC_OP, rvex_pkg::OPC_OP32, rvex_pkg::OPC_LOAD,
			rvex_pkg::OPC_OPIMM, rvex_pkg::OPC_OPIMM32, rvex_pkg::OPC_JALR,
			rvex_pkg::OPC_SYSTEM, rvex_pkg::OPC_STORE, rvex_pkg::OPC_BRANCH,
			rvex_pkg::OPC_AUIPC, rvex_pkg::OPC_LUI, rvex_pkg::OPC_JAL};
		f7s = '{rvex_pkg::F7_BASE, rvex_pkg::F7_MULDIV, rvex_pkg::F7_ALT};
		w = $urandom;
		if ($urandom_range(0, 9) != 0) begin
			w[6:0] = opcodes[$urandom_range(0, 11)];
			if ((w[6:0] == rvex_pkg::OPC_OP || w[6:0] == rvex_pkg::OPC_OP32)
					&& $urandom_range(0, 7) != 0)
				w[31:25] = f7s[$urandom_range(0, 2)];
			if ((w[6:0] == rvex_pkg::OPC_OPIMM || w[6:0] == rvex_pkg::OPC_OPIMM32)
					&& w[14:12] == rvex_pkg::F3_SR && $urandom_range(0, 3) != 0)
				w[30] = $urandom_range(0, 1);
			if ((w[6:0] == rvex_pkg::OPC_OPIMM || w[6:0] == rvex_pkg::OPC_OPIMM32)
					&& $urandom_range(0, 3) != 0)
				w[31:26] = {1'b0, w[30], 4'd0};
		end
		return w;
	endfunction

	task automatic add_beat(input logic [31:0] ins, input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] pc);
		rvex_pkg::issue_t it;
		it.instruction = ins;
		it.source_a = a;
		it.source_b = b;
		it.pc_value = pc;
		pending_beats.push_back(it);
	endtask

	function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [2:0] f3,
			input logic [6:0] opc);
		return {f7, 5'd2, 5'd1, f3, 5'd5, opc};
	endfunction

	// driver: new beat presented at the falling edge once the last one is taken and any random gap has run out
	always @(negedge clk) begin
		if (arst_n) begin
			if (issue_valid && issue_taken) begin
				if (issue_gap > 0 || pending_beats.size() == 0) begin
					issue_valid <= 1'b0;
				end else begin
					issue <= pending_beats.pop_front();
				end
			end else if (!issue_valid && pending_beats.size() != 0) begin
				if (issue_gap > 0) begin
					issue_gap <= issue_gap - 1;
				end else begin
					issue_valid <= 1'b1;
					issue <= pending_beats.pop_front();
				end
			end
		end
	end

	always @(posedge clk) begin
		issue_taken <= arst_n && issue_valid && !issue_stall;
		if (arst_n && issue_valid && !issue_stall) begin
			expected_results.push_back(execute_instruction(issue));
			issue_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
		end
	end

	// monitor: check each accepted result beat against the oldest prediction
	always @(posedge clk) begin
		rvex_pkg::result_t want;
		cycle_count <= cycle_count + 1;
		result_taken <= arst_n && result_valid && !result_stall;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("result beat with no instruction outstanding");
				error_count <= error_count + 1;
			end else begin
				want = expected_results.pop_front();
				if (result !== want) begin
					error_count <= error_count + 1;
					if (result.dest_index !== want.dest_index)
						$error("dest_index exp %0h got %0h", want.dest_index, result.dest_index);
					if (result.dest_write !== want.dest_write)
						$error("dest_write exp %0h got %0h", want.dest_write, result.dest_write);
					if (result.dest_value !== want.dest_value)
						$error("dest_value exp %0h got %0h", want.dest_value, result.dest_value);
					if (result.jump_taken !== want.jump_taken)
						$error("jump_taken exp %0h got %0h", want.jump_taken, result.jump_taken);
					if (result.jump_target !== want.jump_target)
						$error("jump_target exp %0h got %0h", want.jump_target,
							result.jump_target);
					if (result.mem_kind !== want.mem_kind)
						$error("mem_kind exp %0h got %0h", want.mem_kind, result.mem_kind);
					if (result.mem_size_log !== want.mem_size_log)
						$error("mem_size_log exp %0h got %0h", want.mem_size_log,
							result.mem_size_log);
					if (result.mem_signed !== want.mem_signed)
						$error("mem_signed exp %0h got %0h", want.mem_signed, result.mem_signed);
					if (result.mem_address !== want.mem_address)
						$error("mem_address exp %0h got %0h", want.mem_address,
							result.mem_address);
					if (result.store_value !== want.store_value)
						$error("store_value exp %0h got %0h", want.store_value,
							result.store_value);
					if (result.fault !== want.fault)
						$error("fault exp %0h got %0h", want.fault, result.fault);
				end
			end
		end
	end

	// receiver stall: random gaps, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (arst_n) begin
			hold_count <= hold_count + 1;
			if (hold_count >= hold_off_start && hold_count < hold_off_start + 300) begin
				result_stall <= 1'b1;
			end else if (result_gap > 0) begin
				result_gap <= result_gap - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (result_taken)
					result_gap <= (hold_count % 2000 < 600) ? 0 : $urandom_range(0, 5);
			end
		end
	end

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		issue_valid = 1'b0;
		issue = '0;
		result_stall = 1'b0;
		error_count = 0;
		cycle_count = 0;
		hold_count = 0;
		issue_gap = 0;
		result_gap = 0;
		hold_off_start = 300;

		// directed: every operation family, divide corner cases, faults
		add_beat(r_type(rvex_pkg::F7_BASE, rvex_pkg::F3_ADD, rvex_pkg::OPC_OP), '1, 64'd1,
			64'h1000);
		add_beat(r_type(rvex_pkg::F7_ALT, rvex_pkg::F3_ADD, rvex_pkg::OPC_OP), 64'd0, 64'd1,
			64'h1004);
		add_beat(r_type(rvex_pkg::F7_ALT, rvex_pkg::F3_SR, rvex_pkg::OPC_OP),
			64'h8000_0000_0000_0000, 64'd127, 64'h8);
		add_beat(r_type(rvex_pkg::F7_MULDIV, rvex_pkg::F3_MULH, rvex_pkg::OPC_OP), '1,
			64'h8000_0000_0000_0000, 64'h0);
		add_beat(r_type(rvex_pkg::F7_MULDIV, rvex_pkg::F3_DIV, rvex_pkg::OPC_OP),
			64'h8000_0000_0000_0000, '1, 64'h0);
		add_beat(r_type(rvex_pkg::F7_MULDIV, rvex_pkg::F3_REM, rvex_pkg::OPC_OP),
			64'h8000_0000_0000_0000, '1, 64'h0);
		add_beat(r_type(rvex_pkg::F7_MULDIV, rvex_pkg::F3_DIVU, rvex_pkg::OPC_OP), 64'd55,
			64'd0, 64'h0);
		add_beat(r_type(rvex_pkg::F7_MULDIV, rvex_pkg::F3_REMU, rvex_pkg::OPC_OP), 64'd55,
			64'd0, 64'h0);
		add_beat(r_type(rvex_pkg::F7_MULDIV, rvex_pkg::F3_DIV, rvex_pkg::OPC_OP32),
			64'h8000_0000, 64'hffff_ffff, 64'h0);
		add_beat(r_type(rvex_pkg::F7_MULDIV, rvex_pkg::F3_REM, rvex_pkg::OPC_OP32), 64'h1234,
			64'h0, 64'h0);
		add_beat(r_type(rvex_pkg::F7_MULDIV, rvex_pkg::F3_MUL, rvex_pkg::OPC_OP32),
			64'h7fff_ffff, 64'h7fff_ffff, 64'h0);
		add_beat(r_type(rvex_pkg::F7_MULDIV, rvex_pkg::F3_SLT, rvex_pkg::OPC_OP), 64'd1, 64'd2,
			64'h0);
		add_beat({7'h21, 5'd3, 5'd1, rvex_pkg::F3_SR, 5'd4, rvex_pkg::OPC_OPIMM}, '1, '0, '0);
		add_beat({7'h21, 5'd31, 5'd1, rvex_pkg::F3_SR, 5'd4, rvex_pkg::OPC_OPIMM32},
			64'h8000_0000, '0, '0);
		add_beat({12'hfff, 5'd1, rvex_pkg::F3_PLAIN, 5'd0, rvex_pkg::OPC_JALR}, 64'h100, '0,
			64'h40);
		add_beat({20'hfffff, 5'd1, rvex_pkg::OPC_JAL}, '0, '0, 64'h2000);
		add_beat({12'h001, 5'd1, 3'd3, 5'd7, rvex_pkg::OPC_LOAD}, 64'h100, '0, '0);
		add_beat({12'h008, 5'd1, 3'd6, 5'd7, rvex_pkg::OPC_LOAD}, 64'h100, '0, '0);
		add_beat({12'h000, 5'd1, rvex_pkg::LOAD_RESERVED, 5'd7, rvex_pkg::OPC_LOAD}, '0, '0,
			'0);
		add_beat({7'h7f, 5'd2, 5'd1, 3'd3, 5'h1f, rvex_pkg::OPC_STORE}, 64'h101, '1, '0);
		add_beat({7'h00, 5'd2, 5'd1, 3'd1, 5'h02, rvex_pkg::OPC_STORE}, 64'h100, '1, '0);
		add_beat({7'h40, 5'd2, 5'd1, rvex_pkg::F3_BLT, 5'h10, rvex_pkg::OPC_BRANCH}, '1, 64'd0,
			64'h3000);
		add_beat({7'h00, 5'd2, 5'd1, rvex_pkg::F3_BGEU, 5'h10, rvex_pkg::OPC_BRANCH}, 64'd0,
			'1, 64'h3000);
		add_beat({25'h0, rvex_pkg::OPC_SYSTEM}, '0, '0, '0);
		add_beat({20'hfffff, 5'd0, rvex_pkg::OPC_LUI}, '0, '0, '0);
		add_beat({20'h80000, 5'd9, rvex_pkg::OPC_AUIPC}, '0, '0, '1);
		add_beat(32'hffff_ffff, '1, '1, '1);

		repeat (450)
			add_beat(random_instruction(), rand64(), rand64(), rand64());

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_beats.size() != 0 || issue_valid || expected_results.size() != 0) begin
			@(posedge clk);
			if (cycle_count > CYCLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
		wait_cycles = 0;
		while (wait_cycles < LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
